// ----- design/ffra_pkg.sv -----
// ffra_pkg: grid sizes, field widths, mode and status codes and the
// controller/datapath command and status structs of the run allocator.
// No dependencies.
`default_nettype none
package ffra_pkg;

   localparam int NUM_ROWS = 16;
   localparam int NUM_COLS = 16;
   localparam int MAX_RUN  = 4;

   localparam int MODE_W   = 2;
   localparam int LEN_W    = 3;
   localparam int IDX_W    = 4;
   localparam int STATUS_W = 2;
   localparam int ROW_W    = 16;

   // row address width inside the grid, at least one bit
   localparam int ROW_AW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

   // columns that exist; bits above stay zero
   localparam logic [ROW_W-1:0] COL_MASK = ROW_W'((33'd1 << NUM_COLS) - 33'd1);

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR = 2'd0,
      MODE_READ  = 2'd1,
      MODE_RUN   = 2'd2,
      MODE_SLOT  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_LEN = 2'd1,
      ST_NO_FIT  = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   // which fields a result carries besides its status
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_BITS = 2'd1,
      KIND_SLOT = 2'd2,
      KIND_RUN  = 2'd3
   } kind_type;

   typedef struct packed {
      logic       load_item;
      logic       clear_grid;
      logic       claim_slot;
      logic       claim_run;
      logic       scan_start;
      logic       scan_next;
      logic       emit;
      status_type emit_status;
      kind_type   emit_kind;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     len_bad;
      logic     len_too_long;
      logic     row_bad;
      logic     col_bad;
      logic     slot_taken;
      logic     row_fit;
      logic     last_row;
      logic     out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- design/ffra_req_if.sv -----
// ffra_req_if: request channel of the run allocator, valid/ready plus payload.
// Depends on ffra_pkg for field widths.
`default_nettype none
interface ffra_req_if;
   import ffra_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [LEN_W-1:0]  run_length;
   logic [IDX_W-1:0]  row_index;
   logic [IDX_W-1:0]  col_index;

   modport source (output valid, mode, run_length, row_index, col_index, input ready);
   modport sink   (input valid, mode, run_length, row_index, col_index, output ready);
endinterface
`default_nettype wire

// ----- design/ffra_rsp_if.sv -----
// ffra_rsp_if: response channel of the run allocator, valid/ready plus payload.
// Depends on ffra_pkg for field widths.
`default_nettype none
interface ffra_rsp_if;
   import ffra_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    found_row;
   logic [IDX_W-1:0]    found_col;
   logic [ROW_W-1:0]    row_bits;

   modport source (output valid, status, found_row, found_col, row_bits, input ready);
   modport sink   (input valid, status, found_row, found_col, row_bits, output ready);
endinterface
`default_nettype wire

// ----- design/ffra_datapath.sv -----
// ffra_datapath: occupancy grid, latched request, row scan counter, run
// match logic and the response register. Depends on ffra_pkg.
`default_nettype none
module ffra_datapath
   import ffra_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output      dp_status_type       st,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [LEN_W-1:0]    req_run_length,
   input  wire logic [IDX_W-1:0]    req_row_index,
   input  wire logic [IDX_W-1:0]    req_col_index,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic [IDX_W-1:0]    rsp_found_row,
   output      logic [IDX_W-1:0]    rsp_found_col,
   output      logic [ROW_W-1:0]    rsp_row_bits
);

   logic [ROW_W-1:0]    grid_ff [NUM_ROWS];
   logic [ROW_W-1:0]    grid_in [NUM_ROWS];
   mode_type            mode_ff, mode_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [IDX_W-1:0]    row_idx_ff, row_idx_in;
   logic [IDX_W-1:0]    col_idx_ff, col_idx_in;
   logic [ROW_AW-1:0]   row_ctr_ff, row_ctr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [IDX_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]    rsp_bits_ff, rsp_bits_in;

   logic [ROW_W-1:0]    word_rd;
   logic [ROW_W-1:0]    slot_mask;
   logic [ROW_W-1:0]    run_mask;
   logic [ROW_W-1:0]    fit_mask;
   logic [ROW_W-1:0]    fit_vec;
   logic [IDX_W-1:0]    fit_col;

   assign word_rd   = grid_ff[row_ctr_ff];
   assign slot_mask = ROW_W'(1) << col_idx_ff;
   assign run_mask  = ~({ROW_W{1'b1}} << len_ff);

   // one match bit per start column, lowest match wins
   always_comb begin
      fit_vec = '0;
      for (int c = 0; c < ROW_W; c++) begin
         fit_vec[c] = ((5'(c) + 5'(len_ff)) <= 5'(NUM_COLS)) &&
                      ((word_rd & (run_mask << c)) == '0);
      end
      fit_col = '0;
      for (int c = ROW_W - 1; c >= 0; c--) begin
         if (fit_vec[c]) begin
            fit_col = IDX_W'(c);
         end
      end
   end
   assign fit_mask = run_mask << fit_col;

   always_comb begin
      grid_in    = grid_ff;
      mode_in    = mode_ff;
      len_in     = len_ff;
      row_idx_in = row_idx_ff;
      col_idx_in = col_idx_ff;
      row_ctr_in = row_ctr_ff;

      if (cmd.load_item) begin
         mode_in    = mode_type'(req_mode);
         len_in     = req_run_length;
         row_idx_in = req_row_index;
         col_idx_in = req_col_index;
         row_ctr_in = req_row_index[ROW_AW-1:0];
      end
      if (cmd.scan_start) begin
         row_ctr_in = '0;
      end
      if (cmd.scan_next) begin
         row_ctr_in = row_ctr_ff + ROW_AW'(1);
      end
      if (cmd.clear_grid) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            grid_in[r] = '0;
         end
      end
      if (cmd.claim_slot) begin
         grid_in[row_ctr_ff] = (word_rd | slot_mask) & COL_MASK;
      end
      if (cmd.claim_run) begin
         grid_in[row_ctr_ff] = (word_rd | fit_mask) & COL_MASK;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_bits_in   = rsp_bits_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.emit_status;
         rsp_row_in    = '0;
         rsp_col_in    = '0;
         rsp_bits_in   = '0;
         case (cmd.emit_kind)
            KIND_BITS: begin
               rsp_bits_in = word_rd & COL_MASK;
            end
            KIND_SLOT: begin
               rsp_row_in = row_idx_ff;
               rsp_col_in = col_idx_ff;
            end
            KIND_RUN: begin
               rsp_row_in = IDX_W'(row_ctr_ff);
               rsp_col_in = fit_col;
            end
            default: begin
               rsp_row_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            grid_ff[r] <= '0;
         end
         rsp_valid_ff <= 1'b0;
         row_ctr_ff   <= '0;
      end else begin
         grid_ff      <= grid_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ctr_ff   <= row_ctr_in;
      end
      mode_ff       <= mode_in;
      len_ff        <= len_in;
      row_idx_ff    <= row_idx_in;
      col_idx_ff    <= col_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_bits_ff   <= rsp_bits_in;
   end

   assign st.mode         = mode_ff;
   assign st.len_bad      = (len_ff == '0) || (len_ff > LEN_W'(MAX_RUN));
   assign st.len_too_long = 5'(len_ff) > 5'(NUM_COLS);
   assign st.row_bad      = 5'(row_idx_ff) >= 5'(NUM_ROWS);
   assign st.col_bad      = 5'(col_idx_ff) >= 5'(NUM_COLS);
   assign st.slot_taken   = (word_rd & slot_mask) != '0;
   assign st.row_fit      = fit_vec != '0;
   assign st.last_row     = row_ctr_ff == ROW_AW'(NUM_ROWS - 1);
   assign st.out_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found_row = rsp_row_ff;
   assign rsp_found_col = rsp_col_ff;
   assign rsp_row_bits  = rsp_bits_ff;

endmodule
`default_nettype wire

// ----- design/ffra_ctrl.sv -----
// ffra_ctrl: sequencer of the run allocator; decodes the latched mode and
// steps the row scan. Depends on ffra_pkg.
`default_nettype none
module ffra_ctrl
   import ffra_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire dp_status_type st,
   output      dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_SCAN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.emit_status = ST_OK;
      cmd.emit_kind   = KIND_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            case (st.mode)
               MODE_CLEAR: begin
                  if (st.out_free) begin
                     cmd.clear_grid = 1'b1;
                     cmd.emit       = 1'b1;
                     state_in       = S_IDLE;
                  end
               end
               MODE_READ: begin
                  if (st.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = st.row_bad ? ST_RANGE : ST_OK;
                     cmd.emit_kind   = st.row_bad ? KIND_NONE : KIND_BITS;
                     state_in        = S_IDLE;
                  end
               end
               MODE_RUN: begin
                  if (st.len_bad || st.len_too_long) begin
                     if (st.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = st.len_bad ? ST_BAD_LEN : ST_NO_FIT;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               MODE_SLOT: begin
                  if (st.out_free) begin
                     cmd.emit = 1'b1;
                     state_in = S_IDLE;
                     if (st.row_bad || st.col_bad) begin
                        cmd.emit_status = ST_RANGE;
                     end else if (st.slot_taken) begin
                        cmd.emit_status = ST_NO_FIT;
                     end else begin
                        cmd.claim_slot = 1'b1;
                        cmd.emit_kind  = KIND_SLOT;
                     end
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            // a stalled result holds the scan on the current row, nothing written
            if (st.row_fit) begin
               if (st.out_free) begin
                  cmd.claim_run = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_RUN;
                  state_in      = S_IDLE;
               end
            end else if (st.last_row) begin
               if (st.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_NO_FIT;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/first_fit_run_allocator.sv -----
// first_fit_run_allocator: top level, joins the sequencer and the datapath.
// Depends on ffra_pkg, ffra_req_if, ffra_rsp_if, ffra_ctrl, ffra_datapath.
//
//   channel   dir  fields
//   req_chan  in   mode, run_length, row_index, col_index
//   rsp_chan  out  status, found_row, found_col, row_bits
//
// clear, read and single-slot claim latch the request, then act and register the result
// a run search looks at 1 to NUM_ROWS rows in the row scan, which starts at row 0,
// tests one row word per cycle until a hit or the last row and writes back on a hit
// one request at a time; a new request is taken while a result waits
// a waiting result stalls the final step until the response register frees
// synchronous reset empties the grid and the response register
`default_nettype none
module first_fit_run_allocator
   import ffra_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ffra_req_if.sink   req_chan,
   ffra_rsp_if.source rsp_chan
);

   dp_cmd_type    cmd;
   dp_status_type st;

   ffra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   ffra_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_mode       (req_chan.mode),
      .req_run_length (req_chan.run_length),
      .req_row_index  (req_chan.row_index),
      .req_col_index  (req_chan.col_index),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_status     (rsp_chan.status),
      .rsp_found_row  (rsp_chan.found_row),
      .rsp_found_col  (rsp_chan.found_col),
      .rsp_row_bits   (rsp_chan.row_bits)
   );

endmodule
`default_nettype wire

// ----- tb/tb_first_fit_run_allocator.sv -----
// tb_first_fit_run_allocator: self-checking testbench for the first-fit run allocator.
// Depends on ffra_pkg, ffra_req_if, ffra_rsp_if and first_fit_run_allocator.
// A grid predictor queues the expected responses; each response transfer is checked in order.
`timescale 1ns / 1ps
module tb_first_fit_run_allocator;
   import ffra_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = NUM_ROWS + 8;

   typedef struct packed {
      status_type           status;
      logic [IDX_W-1:0]     found_row;
      logic [IDX_W-1:0]     found_col;
      logic [ROW_W-1:0]     row_bits;
   } alloc_rsp_type;

   logic clock;
   logic reset;

   ffra_req_if req_chan ();
   ffra_rsp_if rsp_chan ();

   first_fit_run_allocator u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [ROW_W-1:0] grid_model [NUM_ROWS];
   alloc_rsp_type    pending_rsps [$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // grid occupancy predictor, updated once per accepted request
   function automatic alloc_rsp_type predict_alloc(input mode_type mode,
                                                   input logic [LEN_W-1:0] len,
                                                   input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
      alloc_rsp_type rsp;
      logic [31:0]   run_mask;
      logic          found;
      int            r;
      int            c;
      rsp = '0;
      rsp.status = ST_OK;
      case (mode)
         MODE_CLEAR: begin
            for (r = 0; r < NUM_ROWS; r++) grid_model[r] = '0;
         end
         MODE_READ: begin
            if (row >= NUM_ROWS) rsp.status = ST_RANGE;
            else rsp.row_bits = grid_model[row] & COL_MASK;
         end
         MODE_RUN: begin
            if (len == 0 || len > MAX_RUN) begin
               rsp.status = ST_BAD_LEN;
            end else begin
               rsp.status = ST_NO_FIT;
               found = 1'b0;
               if (len <= NUM_COLS) begin
                  for (r = 0; r < NUM_ROWS && !found; r++) begin
                     for (c = 0; c + len <= NUM_COLS && !found; c++) begin
                        run_mask = ((32'd1 << len) - 32'd1) << c;
                        if (({16'b0, grid_model[r]} & run_mask) == 32'd0) begin
                           grid_model[r] = (grid_model[r] | run_mask[ROW_W-1:0]) & COL_MASK;
                           rsp.status    = ST_OK;
                           rsp.found_row = r[IDX_W-1:0];
                           rsp.found_col = c[IDX_W-1:0];
                           found         = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         default: begin
            if (row >= NUM_ROWS || col >= NUM_COLS) begin
               rsp.status = ST_RANGE;
            end else if (grid_model[row][col]) begin
               rsp.status = ST_NO_FIT;
            end else begin
               grid_model[row][col] = 1'b1;
               rsp.found_row = row;
               rsp.found_col = col;
            end
         end
      endcase
      return rsp;
   endfunction

   // valid stays high into the next request; only an idle cycle or wait_for_drain drops it
   task automatic send_request(input mode_type mode, input logic [LEN_W-1:0] len,
                               input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= mode;
      req_chan.run_length <= len;
      req_chan.row_index  <= row;
      req_chan.col_index  <= col;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_rsps.push_back(predict_alloc(mode, len, row, col));
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input alloc_rsp_type want,
                                  input alloc_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at cycle %0d: %s", cycle_count, what,
                  " expected st=%0d row=%0d col=%0d bits=%h,", want.status,
                  want.found_row, want.found_col, want.row_bits,
                  " got st=%0d row=%0d col=%0d bits=%h", got.status,
                  got.found_row, got.found_col, got.row_bits);
   endtask

   task automatic check_response();
      alloc_rsp_type want;
      alloc_rsp_type got;
      got.status    = status_type'(rsp_chan.status);
      got.found_row = rsp_chan.found_row;
      got.found_col = rsp_chan.found_col;
      got.row_bits  = rsp_chan.row_bits;
      if (pending_rsps.size() == 0) begin
         report_mismatch("unexpected response", '0, got);
      end else begin
         want = pending_rsps.pop_front();
         if (got.status !== want.status) report_mismatch("status", want, got);
         else if (got.found_row !== want.found_row) report_mismatch("found_row", want, got);
         else if (got.found_col !== want.found_col) report_mismatch("found_col", want, got);
         else if (got.row_bits !== want.row_bits) report_mismatch("row_bits", want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) check_response();
      rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic test_clear_and_read();
      send_request(MODE_CLEAR, 3'd0, 4'd0, 4'd0);
      send_request(MODE_READ, 3'd0, 4'd0, 4'd0);
      send_request(MODE_READ, 3'd7, 4'd15, 4'd15);
   endtask

   task automatic test_run_search();
      send_request(MODE_RUN, 3'd1, 4'd0, 4'd0);
      send_request(MODE_RUN, 3'd4, 4'd15, 4'd15);
      send_request(MODE_RUN, 3'd3, 4'd0, 4'd0);
      send_request(MODE_READ, 3'd0, 4'd0, 4'd0);
      send_request(MODE_RUN, 3'd2, 4'd5, 4'd10);
   endtask

   task automatic test_bad_lengths();
      send_request(MODE_RUN, 3'd0, 4'd0, 4'd0);
      send_request(MODE_RUN, 3'd5, 4'd0, 4'd0);
      send_request(MODE_RUN, 3'd6, 4'd15, 4'd15);
      send_request(MODE_RUN, 3'd7, 4'd0, 4'd0);
      send_request(MODE_READ, 3'd0, 4'd0, 4'd0);
   endtask

   task automatic test_slot_claims();
      send_request(MODE_SLOT, 3'd0, 4'd0, 4'd12);
      send_request(MODE_SLOT, 3'd0, 4'd0, 4'd12);
      send_request(MODE_SLOT, 3'd7, 4'd15, 4'd15);
      send_request(MODE_SLOT, 3'd0, 4'd15, 4'd0);
      send_request(MODE_READ, 3'd0, 4'd15, 4'd0);
      send_request(MODE_RUN, 3'd4, 4'd0, 4'd0);
      send_request(MODE_CLEAR, 3'd7, 4'd15, 4'd15);
      send_request(MODE_READ, 3'd0, 4'd15, 4'd0);
   endtask

   // clear, then mostly allocations so the grid fills up and searches start to fail
   task automatic test_fill_grid(input int num_items);
      int pick;
      int n;
      send_request(MODE_CLEAR, LEN_W'($urandom_range(7)), IDX_W'($urandom_range(15)),
                   IDX_W'($urandom_range(15)));
      for (n = 1; n < num_items; n++) begin
         pick = $urandom_range(99);
         if (pick < 60)
            send_request(MODE_RUN, LEN_W'($urandom_range(1, MAX_RUN)),
                         IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)));
         else if (pick < 75)
            send_request(MODE_SLOT, LEN_W'($urandom_range(7)),
                         IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)));
         else if (pick < 86)
            send_request(MODE_READ, LEN_W'($urandom_range(7)),
                         IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)));
         else if (pick < 93)
            send_request(MODE_RUN,
                         LEN_W'(($urandom_range(1) != 0) ? 0 : $urandom_range(5, 7)),
                         IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)));
         else
            send_request(MODE_RUN, LEN_W'($urandom_range(7)),
                         IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)));
      end
   endtask

   task automatic test_random_noise(input int num_items);
      int n;
      for (n = 0; n < num_items; n++)
         send_request(mode_type'($urandom_range(3)), LEN_W'($urandom_range(7)),
                      IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)));
   endtask

   initial begin
      int phase;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_CLEAR;
      req_chan.run_length = '0;
      req_chan.row_index  = '0;
      req_chan.col_index  = '0;
      rsp_chan.ready      = 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) grid_model[r] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_clear_and_read();
      test_run_search();
      test_bad_lengths();
      test_slot_claims();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
            default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
         endcase
         test_fill_grid(190);
         // after phase 1, hold off until every outstanding response has come back
         if (phase == 1) wait_for_drain();
         test_random_noise(35);
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsps.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- files.f -----
design/ffra_pkg.sv
design/ffra_req_if.sv
design/ffra_rsp_if.sv
design/ffra_datapath.sv
design/ffra_ctrl.sv
design/first_fit_run_allocator.sv
tb/tb_first_fit_run_allocator.sv
